// ===== rtl/kdpd_pkg.sv =====
// Shared types and constants for the key debounce press detector.
package kdpd_pkg;

  // Width of the raw switch word and of the packed flag outputs
  localparam int unsigned RAW_WIDTH = 16;
  localparam int unsigned OUT_WIDTH = 16;
  localparam int unsigned PIN_IDX_W = 8;

  // Operation codes carried by an input transaction
  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_LEVEL  = 2'd1,
    OP_PULSE  = 2'd2
  } op_e;

  // Per-pin debounce phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ONE  = 2'd1,
    PH_TWO  = 2'd2,
    PH_HELD = 2'd3
  } phase_e;

  // Broadcast control to every lane, already qualified by the accept strobe
  typedef struct packed {
    logic sample;
    logic rd_level;
    logic rd_pulse;
  } lane_ctrl_t;

  // Lane status toward the merge stage: flags after this transaction and
  // the queried flag before clearing
  typedef struct packed {
    logic level;
    logic pulse;
    logic flag;
  } lane_stat_t;

endpackage

// ===== rtl/kdpd_lane.sv =====
// One debounce lane: phase machine and level/pulse flags of a single pin.
module kdpd_lane
  import kdpd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lane_ctrl_t ctrl_i,
  input  logic       pressed_i,
  input  logic       sel_i,
  output lane_stat_t stat_o
);

  phase_e phase_q, phase_d;
  logic   level_q, level_d;
  logic   pulse_q, pulse_d;
  logic   flag;

  // Compute next phase and flags for a sample or a query
  always_comb begin
    phase_d = phase_q;
    level_d = level_q;
    pulse_d = pulse_q;
    flag    = 1'b0;
    if (ctrl_i.sample) begin
      case (phase_q)
        PH_IDLE: begin
          if (pressed_i) begin
            level_d = 1'b0;
            pulse_d = 1'b0;
            phase_d = PH_ONE;
          end
        end
        PH_ONE: begin
          if (pressed_i) begin
            level_d = 1'b0;
            pulse_d = 1'b0;
            phase_d = PH_TWO;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_TWO: begin
          if (pressed_i) begin
            level_d = 1'b1;
            pulse_d = 1'b1;
            phase_d = PH_HELD;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          if (pressed_i) begin
            level_d = 1'b1;
            pulse_d = 1'b0;
          end else begin
            level_d = 1'b0;
            pulse_d = 1'b0;
            phase_d = PH_IDLE;
          end
        end
      endcase
    end else if (ctrl_i.rd_level && sel_i) begin
      flag    = level_q;
      level_d = 1'b0;
    end else if (ctrl_i.rd_pulse && sel_i) begin
      flag    = pulse_q;
      pulse_d = 1'b0;
    end
  end

  // Hold lane state; the control is zero outside accepted transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      level_q <= 1'b0;
      pulse_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      level_q <= level_d;
      pulse_q <= pulse_d;
    end
  end

  assign stat_o.level = level_d;
  assign stat_o.pulse = pulse_d;
  assign stat_o.flag  = flag;

endmodule

// ===== rtl/kdpd_merge.sv =====
// Merge stage: combine lane results into the registered output transaction.
module kdpd_merge
  import kdpd_pkg::*;
#(
  parameter int unsigned PIN_COUNT = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  lane_stat_t           stat_i [PIN_COUNT],
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output logic                 flag_o,
  output logic [OUT_WIDTH-1:0] level_bits_o,
  output logic [OUT_WIDTH-1:0] pulse_bits_o
);

  logic                 valid_q, valid_d;
  logic                 flag_q;
  logic [OUT_WIDTH-1:0] level_q, pulse_q;
  logic [PIN_COUNT-1:0] flag_vec;
  logic [OUT_WIDTH-1:0] level_pack, pulse_pack;

  // Gather the queried flag; only the selected lane can drive it
  for (genvar i = 0; i < PIN_COUNT; i++) begin : g_flag
    assign flag_vec[i] = stat_i[i].flag;
  end

  // Pack the visible pins; pins that do not exist read as zero
  for (genvar i = 0; i < OUT_WIDTH; i++) begin : g_pack
    if (i < PIN_COUNT) begin : g_pin
      assign level_pack[i] = stat_i[i].level;
      assign pulse_pack[i] = stat_i[i].pulse;
    end else begin : g_none
      assign level_pack[i] = 1'b0;
      assign pulse_pack[i] = 1'b0;
    end
  end

  // Set valid on accept, drop it when the receiver takes the transaction
  always_comb begin
    valid_d = valid_q;
    if (accept_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load the payload only on accept
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      flag_q  <= |flag_vec;
      level_q <= level_pack;
      pulse_q <= pulse_pack;
    end
  end

  assign out_valid_o  = valid_q;
  assign flag_o       = flag_q;
  assign level_bits_o = level_q;
  assign pulse_bits_o = pulse_q;

endmodule

// ===== rtl/key_debounce_press_detector.sv =====
// Top level of the key debounce press detector for active-low switches.
//
// Input channel (in_valid_i/in_ready_o) carries op_i, raw_bits_i and
// pin_index_i. A sample transaction inverts each raw bit into a pressed
// flag and advances that pin's phase machine; three pressed samples in a
// row set the pin's level flag and a one-sample pulse flag. A level or
// pulse query returns the pin's flag in flag_o and clears it; a pin at or
// beyond PIN_COUNT returns zero and changes nothing.
// Output channel (out_valid_o/out_ready_i) gives one result per input
// transaction: flag_o, plus level_bits_o and pulse_bits_o for pins 0..15
// after the transaction.
// The result appears the cycle after accept. One transaction per cycle is
// sustained while the receiver is ready, set by the single output register
// behind the per-pin lanes, which all update in the accepting cycle.
// When the receiver stalls, the result holds and in_ready_o drops until
// it is taken; in_ready_o is high in the same cycle out_ready_i is high.
// Reset puts every pin in the idle phase with both flags cleared and
// empties the output register.
module key_debounce_press_detector
  import kdpd_pkg::*;
#(
  parameter int unsigned PIN_COUNT = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           op_i,
  input  logic [RAW_WIDTH-1:0] raw_bits_i,
  input  logic [PIN_IDX_W-1:0] pin_index_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 flag_o,
  output logic [OUT_WIDTH-1:0] level_bits_o,
  output logic [OUT_WIDTH-1:0] pulse_bits_o
);

  logic       accept;
  lane_ctrl_t ctrl;
  lane_stat_t stat [PIN_COUNT];

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Decode the operation into lane control
  always_comb begin
    ctrl = '0;
    if (accept) begin
      case (op_e'(op_i))
        OP_SAMPLE: ctrl.sample   = 1'b1;
        OP_LEVEL:  ctrl.rd_level = 1'b1;
        OP_PULSE:  ctrl.rd_pulse = 1'b1;
        default:   ctrl = '0;
      endcase
    end
  end

  // One lane per pin; pins past the raw word always see a release
  for (genvar i = 0; i < PIN_COUNT; i++) begin : g_lane
    logic pressed;
    logic sel;
    if (i < RAW_WIDTH) begin : g_raw
      assign pressed = !raw_bits_i[i];
    end else begin : g_rel
      assign pressed = 1'b0;
    end
    assign sel = (pin_index_i == PIN_IDX_W'(i));

    kdpd_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .pressed_i (pressed),
      .sel_i     (sel),
      .stat_o    (stat[i])
    );
  end

  kdpd_merge #(
    .PIN_COUNT (PIN_COUNT)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .stat_i       (stat),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .flag_o       (flag_o),
    .level_bits_o (level_bits_o),
    .pulse_bits_o (pulse_bits_o)
  );

  // Every accepted transaction shows up as a result in the next cycle
  a_accept_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted transaction did not produce a result");

  // A sample never reports a queried flag
  a_sample_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_SAMPLE) |=> !flag_o)
    else $error("sample transaction returned a set flag");

  // A level query leaves the queried level bit cleared
  a_level_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_LEVEL && pin_index_i < PIN_IDX_W'(OUT_WIDTH))
    |=> !level_bits_o[$past(pin_index_i[3:0])])
    else $error("level flag still set after read-and-clear");

  // A pulse query leaves the queried pulse bit cleared
  a_pulse_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == OP_PULSE && pin_index_i < PIN_IDX_W'(OUT_WIDTH))
    |=> !pulse_bits_o[$past(pin_index_i[3:0])])
    else $error("pulse flag still set after read-and-clear");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the key debounce press detector.
module tb
  import kdpd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PINS        = 16;
  localparam logic [1:0]  OP_SPARE    = 2'd3;
  localparam int unsigned STALL_LIMIT = 1000;

  typedef struct packed {
    logic        flag;
    logic [15:0] level;
    logic [15:0] pulse;
  } press_result_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i         = OP_SAMPLE;
  logic [15:0] raw_bits_i   = '1;
  logic [7:0]  pin_index_i  = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        flag_o;
  logic [15:0] level_bits_o;
  logic [15:0] pulse_bits_o;

  // Predicted per-pin state
  phase_e      pin_phase [PINS];
  logic [15:0] level_q;
  logic [15:0] pulse_q;

  press_result_t expected_q[$];
  int            errors        = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            stall_cycles  = 0;
  logic [15:0]   switches      = '1;

  key_debounce_press_detector #(.PIN_COUNT(PINS)) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .raw_bits_i   (raw_bits_i),
    .pin_index_i  (pin_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .flag_o       (flag_o),
    .level_bits_o (level_bits_o),
    .pulse_bits_o (pulse_bits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Advance the predicted debounce state by one transaction
  function automatic press_result_t debounce_predict(logic [1:0] op, logic [15:0] raw,
                                                     logic [7:0] pin);
    press_result_t r;
    logic          pressed;
    r = '0;
    if (op == OP_SAMPLE) begin
      for (int p = 0; p < PINS; p++) begin
        pressed = ~raw[p];
        case (pin_phase[p])
          PH_IDLE: begin
            if (pressed) begin
              level_q[p]   = 1'b0;
              pulse_q[p]   = 1'b0;
              pin_phase[p] = PH_ONE;
            end
          end
          PH_ONE: begin
            if (pressed) begin
              level_q[p]   = 1'b0;
              pulse_q[p]   = 1'b0;
              pin_phase[p] = PH_TWO;
            end else begin
              pin_phase[p] = PH_IDLE;
            end
          end
          PH_TWO: begin
            if (pressed) begin
              level_q[p]   = 1'b1;
              pulse_q[p]   = 1'b1;
              pin_phase[p] = PH_HELD;
            end else begin
              pin_phase[p] = PH_IDLE;
            end
          end
          default: begin
            if (pressed) begin
              level_q[p] = 1'b1;
              pulse_q[p] = 1'b0;
            end else begin
              level_q[p]   = 1'b0;
              pulse_q[p]   = 1'b0;
              pin_phase[p] = PH_IDLE;
            end
          end
        endcase
      end
    end else if (op == OP_LEVEL) begin
      if (pin < PINS) begin
        r.flag            = level_q[pin[3:0]];
        level_q[pin[3:0]] = 1'b0;
      end
    end else if (op == OP_PULSE) begin
      if (pin < PINS) begin
        r.flag            = pulse_q[pin[3:0]];
        pulse_q[pin[3:0]] = 1'b0;
      end
    end
    r.level = level_q;
    r.pulse = pulse_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    $display("ERROR at %0t ns: %s expected %h got %h", $time, what, want, got);
    errors++;
  endtask

  // Drive one transaction from a falling edge and hold it until accepted
  task automatic send_item(logic [1:0] op, logic [15:0] raw, logic [7:0] pin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    raw_bits_i  <= raw;
    pin_index_i <= pin;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(debounce_predict(op, raw, pin));
    @(negedge clk_i);
  endtask

  // Receiver backpressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    press_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, level_bits", '0, level_bits_o);
      end else begin
        want = expected_q.pop_front();
        if (flag_o !== want.flag) report_mismatch("flag", 16'(want.flag), 16'(flag_o));
        if (level_bits_o !== want.level) report_mismatch("level_bits", want.level, level_bits_o);
        if (pulse_bits_o !== want.pulse) report_mismatch("pulse_bits", want.pulse, pulse_bits_o);
      end
    end
  end

  // Drop the run if nothing moves while work is pending
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (!in_valid_i && expected_q.size() == 0)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_reset_flags();
    send_item(OP_LEVEL, '0, 8'd0);
    send_item(OP_PULSE, '1, 8'd15);
  endtask

  // Hold every switch for three samples, read the flags, hold one more sample, then release
  task automatic test_press_and_hold();
    send_item(OP_SAMPLE, 16'hFFFF, 8'd0);
    repeat (3) send_item(OP_SAMPLE, 16'h0000, 8'hFF);
    send_item(OP_PULSE, 16'h0000, 8'd15);
    send_item(OP_LEVEL, 16'hFFFF, 8'd7);
    send_item(OP_SAMPLE, 16'h0000, 8'd3);
    send_item(OP_SAMPLE, 16'hFFFF, 8'd0);
  endtask

  // Release after one and after two pressed samples
  task automatic test_bounce_release();
    repeat (2) send_item(OP_SAMPLE, 16'h00FF, 8'd0);
    send_item(OP_SAMPLE, 16'hFF00, 8'd0);
    send_item(OP_SAMPLE, 16'hFFFF, 8'd0);
  endtask

  // Out-of-range pins and the unused opcode leave state alone
  task automatic test_bad_pin_and_spare_op();
    repeat (3) send_item(OP_SAMPLE, 16'h0000, 8'd0);
    send_item(OP_LEVEL, 16'h0000, 8'd16);
    send_item(OP_PULSE, 16'h0000, 8'd255);
    send_item(OP_SPARE, 16'h0000, 8'd0);
    send_item(OP_LEVEL, 16'h0000, 8'd0);
  endtask

  // Mostly slow-moving switch patterns so presses reach the held phase
  task automatic test_random_traffic(int n_items, int s_idle, int r_idle);
    int          pick;
    logic [1:0]  op;
    logic [7:0]  pin;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      op   = (pick < 68) ? OP_SAMPLE : (pick < 83) ? OP_LEVEL :
             (pick < 97) ? OP_PULSE : OP_SPARE;
      pin  = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
      if (op == OP_SAMPLE) begin
        if ($urandom_range(19) == 0) begin
          switches = 16'($urandom);
        end else begin
          for (int b = 0; b < 16; b++)
            if ($urandom_range(5) == 0) switches[b] = ~switches[b];
        end
        send_item(op, switches, pin);
      end else begin
        send_item(op, 16'($urandom), pin);
      end
    end
  endtask

  initial begin
    for (int p = 0; p < PINS; p++) pin_phase[p] = PH_IDLE;
    level_q = '0;
    pulse_q = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 17;
    recv_idle_pct = 61;
    test_reset_flags();
    test_press_and_hold();
    test_bounce_release();
    test_bad_pin_and_spare_op();
    test_random_traffic(620, 17, 61);
    test_random_traffic(620, 61, 17);
    test_random_traffic(620, 0, 0);

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
